// ----- design/yrck_pkg.sv -----
// Package for the YUYV to RGBA converter with chroma key.
// Holds payload and configuration types, register indexes and coefficients.
// No dependencies.
package yrck_pkg;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_RED       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_GREEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BLUE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TOLERANCE = 3'd4;

  // Register reset values
  localparam logic       RST_KEY_ENABLE    = 1'b1;
  localparam logic [7:0] RST_KEY_RED       = 8'd0;
  localparam logic [7:0] RST_KEY_GREEN     = 8'd70;
  localparam logic [7:0] RST_KEY_BLUE      = 8'd70;
  localparam logic [7:0] RST_KEY_TOLERANCE = 8'd30;

  // BT.601 integer coefficients, 8 fractional bits
  localparam int unsigned ACC_W = 20;
  localparam logic signed [ACC_W-1:0] COEF_Y     = 20'sd298;
  localparam logic signed [ACC_W-1:0] COEF_RV    = 20'sd409;
  localparam logic signed [ACC_W-1:0] COEF_GU    = 20'sd100;
  localparam logic signed [ACC_W-1:0] COEF_GV    = 20'sd208;
  localparam logic signed [ACC_W-1:0] COEF_BU    = 20'sd516;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 20'sd128;
  localparam logic signed [ACC_W-1:0] CHROMA_OFS = 20'sd128;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Input macropixel
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_item_t;

  // Two RGBA pixels
  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] alpha_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic [7:0] alpha_second;
  } out_item_t;

  // One converted pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // Key settings
  typedef struct packed {
    logic       enable;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] tolerance;
  } key_cfg_t;

endpackage

// ----- design/yrck_cfg.sv -----
// Key configuration registers, written through the cfg channel.
// Depends on yrck_pkg.
module yrck_cfg
  import yrck_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output key_cfg_t              key_cfg
);

  key_cfg_t key_cfg_r;
  key_cfg_t key_cfg_nxt;

  // Always able to take a write
  assign cfg_ready = 1'b1;

  // Decode write; unknown indexes are dropped
  always_comb begin
    key_cfg_nxt = key_cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_ENABLE:    key_cfg_nxt.enable    = cfg_data[0];
        REG_KEY_RED:       key_cfg_nxt.red       = cfg_data;
        REG_KEY_GREEN:     key_cfg_nxt.green     = cfg_data;
        REG_KEY_BLUE:      key_cfg_nxt.blue      = cfg_data;
        REG_KEY_TOLERANCE: key_cfg_nxt.tolerance = cfg_data;
        default:           key_cfg_nxt = key_cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cfg_r.enable    <= RST_KEY_ENABLE;
      key_cfg_r.red       <= RST_KEY_RED;
      key_cfg_r.green     <= RST_KEY_GREEN;
      key_cfg_r.blue      <= RST_KEY_BLUE;
      key_cfg_r.tolerance <= RST_KEY_TOLERANCE;
    end else begin
      key_cfg_r <= key_cfg_nxt;
    end
  end

  assign key_cfg = key_cfg_r;

endmodule

// ----- design/yrck_pixel.sv -----
// Combinational conversion of one luma sample plus shared chroma to RGBA,
// with clamping and chroma key. Depends on yrck_pkg.
module yrck_pixel
  import yrck_pkg::*;
(
  input  logic [7:0] luma,
  input  logic [7:0] chroma_b,
  input  logic [7:0] chroma_r,
  input  key_cfg_t   key_cfg,
  output pixel_t     pixel
);

  logic signed [ACC_W-1:0] y_s;
  logic signed [ACC_W-1:0] u_s;
  logic signed [ACC_W-1:0] v_s;
  logic signed [ACC_W-1:0] r_acc;
  logic signed [ACC_W-1:0] g_acc;
  logic signed [ACC_W-1:0] b_acc;
  logic [7:0]              r_cl;
  logic [7:0]              g_cl;
  logic [7:0]              b_cl;
  logic                    keyed;

  // Floor of acc/256, clamped to 0..255
  function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[ACC_W-1]) begin
      res = 8'd0;
    end else if (|acc[ACC_W-2:16]) begin
      res = 8'hFF;
    end else begin
      res = acc[15:8];
    end
    return res;
  endfunction

  // |a - b| <= tol
  function automatic logic near8(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] tol);
    logic [7:0] gap;
    gap = (a > b) ? (a - b) : (b - a);
    return gap <= tol;
  endfunction

  // Remove chroma offset
  assign y_s = $signed({{(ACC_W-8){1'b0}}, luma});
  assign u_s = $signed({{(ACC_W-8){1'b0}}, chroma_b}) - CHROMA_OFS;
  assign v_s = $signed({{(ACC_W-8){1'b0}}, chroma_r}) - CHROMA_OFS;

  // Matrix with rounding
  assign r_acc = y_s * COEF_Y + v_s * COEF_RV + ROUND_HALF;
  assign g_acc = y_s * COEF_Y - u_s * COEF_GU - v_s * COEF_GV + ROUND_HALF;
  assign b_acc = y_s * COEF_Y + u_s * COEF_BU + ROUND_HALF;

  assign r_cl = clamp8(r_acc);
  assign g_cl = clamp8(g_acc);
  assign b_cl = clamp8(b_acc);

  // Key match on clamped channels
  assign keyed = key_cfg.enable
              && near8(r_cl, key_cfg.red,   key_cfg.tolerance)
              && near8(g_cl, key_cfg.green, key_cfg.tolerance)
              && near8(b_cl, key_cfg.blue,  key_cfg.tolerance);

  always_comb begin
    if (keyed) begin
      pixel = '0;
    end else begin
      pixel.red   = r_cl;
      pixel.green = g_cl;
      pixel.blue  = b_cl;
      pixel.alpha = ALPHA_OPAQUE;
    end
  end

endmodule

// ----- design/yuyv_to_rgba_chroma_key.sv -----
// YUYV macropixel to two RGBA pixels with chroma key, top level.
// Each macropixel is held in the input register, then in the result
// register, from which it is transferred on the result channel.
// Throughput: one macropixel per cycle, limited only by out_stall.
// Synchronous active-low reset empties both stages and loads the key
// registers with their defaults. Depends on yrck_pkg.
module yuyv_to_rgba_chroma_key
  import yrck_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // Configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  key_cfg_t  key_cfg;
  logic      in_valid_r;
  logic      in_valid_nxt;
  in_item_t  in_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  pixel_t    pix_first;
  pixel_t    pix_second;
  logic      out_free;
  logic      in_take;

  yrck_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_cfg   (key_cfg)
  );

  // Pipeline control: each stage moves when the one after it can take it
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !out_free);
  assign out_valid_nxt = out_free ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // Conversion of both pixels
  yrck_pixel u_pix_first (
    .luma     (in_data_r.luma_first),
    .chroma_b (in_data_r.chroma_blue),
    .chroma_r (in_data_r.chroma_red),
    .key_cfg  (key_cfg),
    .pixel    (pix_first)
  );

  yrck_pixel u_pix_second (
    .luma     (in_data_r.luma_second),
    .chroma_b (in_data_r.chroma_blue),
    .chroma_r (in_data_r.chroma_red),
    .key_cfg  (key_cfg),
    .pixel    (pix_second)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (out_free && in_valid_r) begin
      out_data_r.red_first    <= pix_first.red;
      out_data_r.green_first  <= pix_first.green;
      out_data_r.blue_first   <= pix_first.blue;
      out_data_r.alpha_first  <= pix_first.alpha;
      out_data_r.red_second   <= pix_second.red;
      out_data_r.green_second <= pix_second.green;
      out_data_r.blue_second  <= pix_second.blue;
      out_data_r.alpha_second <= pix_second.alpha;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
